// ===== src/motor_soft_start_ramp_assert.svh =====
// Assertion macros shared by the motor soft-start ramp RTL.
`ifndef MOTOR_SOFT_START_RAMP_ASSERT_SVH
`define MOTOR_SOFT_START_RAMP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MSSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mssr_pkg.sv =====
// Package: widths, register codes, reset values and phase codes of the ramp block.
package mssr_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CMP_W      = 16;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PROD_W     = 2 * CMP_W;

  // quotient bits resolved per divider stage (must divide CMP_W)
  localparam int unsigned DIV_BITS = 4;

  localparam logic [TIME_W-1:0] START_RST   = 32'd0;
  localparam logic [CMP_W-1:0]  WAIT_RST    = 16'd0;
  localparam logic [CMP_W-1:0]  RAMP_RST    = 16'd1000;
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd30000;
  localparam logic [CMP_W-1:0]  TARGET_RST  = 16'd0;
  localparam logic [CMP_W-1:0]  PERIOD_RST  = 16'd999;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START   = 3'd0,
    CFG_WAIT    = 3'd1,
    CFG_RAMP    = 3'd2,
    CFG_TIMEOUT = 3'd3,
    CFG_TARGET  = 3'd4,
    CFG_PERIOD  = 3'd5
  } cfg_idx_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_WAIT    = 2'd0,
    PH_RAMP    = 2'd1,
    PH_CRUISE  = 2'd2,
    PH_TIMEOUT = 2'd3
  } phase_e;

endpackage

// ===== src/mssr_if.sv =====
// Interfaces: time stamp input, compare result output and register write channels.
interface mssr_in_if;
  logic                        valid;
  logic                        ready;
  logic [mssr_pkg::TIME_W-1:0] now_ms;
  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

interface mssr_out_if;
  logic                         valid;
  logic                         ready;
  logic [mssr_pkg::CMP_W-1:0]   compare_one;
  logic [mssr_pkg::CMP_W-1:0]   compare_two;
  logic [mssr_pkg::PHASE_W-1:0] phase;
  modport source (output valid, output compare_one, output compare_two, output phase,
                  input ready);
  modport sink   (input valid, input compare_one, input compare_two, input phase,
                  output ready);
endinterface

interface mssr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mssr_pkg::CFG_IDX_W-1:0]  index;
  logic [mssr_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/mssr_div_step.sv =====
// Divider slice: resolves Bits quotient bits of a restoring division.
module mssr_div_step #(
  parameter int unsigned Bits = mssr_pkg::DIV_BITS
) (
  input  logic [mssr_pkg::PROD_W-1:0] word_i,
  input  logic [mssr_pkg::CMP_W-1:0]  divisor_i,
  output logic [mssr_pkg::PROD_W-1:0] word_o
);
  import mssr_pkg::*;

  // word holds {partial remainder, dividend bits left / quotient bits so far}
  logic [PROD_W-1:0] w;
  logic [CMP_W:0]    r;
  logic [CMP_W:0]    t;

  always_comb begin
    w = word_i;
    r = '0;
    t = '0;
    for (int i = 0; i < Bits; i++) begin
      r = {w[PROD_W-1:CMP_W], w[CMP_W-1]};
      t = r - {1'b0, divisor_i};
      if (r >= {1'b0, divisor_i}) begin
        w = {t[CMP_W-1:0], w[CMP_W-2:0], 1'b1};
      end else begin
        w = {r[CMP_W-1:0], w[CMP_W-2:0], 1'b0};
      end
    end
    word_o = w;
  end

endmodule

// ===== src/motor_soft_start_ramp.sv =====
// Motor soft-start ramp: time stamp in, two PWM compares and a phase code out.
//
// Each accepted now_ms item yields one result item, in order. The block is a
// stallable pipeline of 4 + 16/DivBits register stages (8 with the default
// DivBits of 4): elapsed time, schedule decode, 16x16 multiply, the restoring
// divide by ramp_ms in 16/DivBits slices of DivBits quotient bits each, then
// clamp and coast selection into the output register. One item enters per
// cycle while in_i.ready is high. When the sink stalls, items
// close up behind the output register and in_i.ready drops only once every
// stage holds an item. Registers are written through cfg_i (index 0 start
// time, 1 wait, 2 ramp, 3 run timeout, 4 target, 5 period; other indexes are
// ignored) and must only change while no item is in flight. cfg_i is always
// ready.
`include "motor_soft_start_ramp_assert.svh"

module motor_soft_start_ramp #(
  parameter int unsigned DivBits = mssr_pkg::DIV_BITS
) (
  input logic        clk_i,
  input logic        rst_ni,
  mssr_in_if.sink    in_i,
  mssr_out_if.source out_o,
  mssr_cfg_if.sink   cfg_i
);
  import mssr_pkg::*;

  localparam int unsigned DivStages = CMP_W / DivBits;
  localparam int unsigned NumStages = 4 + DivStages;
  localparam int unsigned DivFirst  = 3;
  localparam int unsigned Last      = NumStages - 1;

  // ---------------- configuration registers ----------------
  logic [TIME_W-1:0] start_q, timeout_q;
  logic [CMP_W-1:0]  wait_q, ramp_q, target_q, period_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= START_RST;
      wait_q    <= WAIT_RST;
      ramp_q    <= RAMP_RST;
      timeout_q <= TIMEOUT_RST;
      target_q  <= TARGET_RST;
      period_q  <= PERIOD_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_START:   start_q   <= cfg_i.data;
        CFG_WAIT:    wait_q    <= cfg_i.data[CMP_W-1:0];
        CFG_RAMP:    ramp_q    <= cfg_i.data[CMP_W-1:0];
        CFG_TIMEOUT: timeout_q <= cfg_i.data;
        CFG_TARGET:  target_q  <= cfg_i.data[CMP_W-1:0];
        CFG_PERIOD:  period_q  <= cfg_i.data[CMP_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  // adv[k]: stage k may load this cycle (empty, or its item moves on)
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] adv;

  assign adv[Last] = !v_q[Last] || out_o.ready;
  for (genvar k = 0; k < Last; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end

  assign in_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------- stage 0: elapsed time ----------------
  logic [TIME_W-1:0] elapsed_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      elapsed_q <= in_i.now_ms - start_q;  // wraps modulo 2^32
    end
  end

  // ---------------- stage 1: schedule decode ----------------
  logic [TIME_W-1:0] moving;
  logic              waiting;
  phase_e            s1_phase_d, s1_phase_q;
  logic [CMP_W-1:0]  s1_mov_q;

  assign waiting = elapsed_q < {{(TIME_W-CMP_W){1'b0}}, wait_q};
  assign moving  = elapsed_q - {{(TIME_W-CMP_W){1'b0}}, wait_q};

  // timeout wins over ramp end
  always_comb begin
    priority if (waiting) begin
      s1_phase_d = PH_WAIT;
    end else if (moving >= timeout_q) begin
      s1_phase_d = PH_TIMEOUT;
    end else if (moving >= {{(TIME_W-CMP_W){1'b0}}, ramp_q}) begin
      s1_phase_d = PH_CRUISE;
    end else begin
      s1_phase_d = PH_RAMP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_phase_q <= s1_phase_d;
      s1_mov_q   <= moving[CMP_W-1:0];  // exact while ramping: moving < ramp_ms
    end
  end

  // ---------------- stage 2: target * moving ----------------
  phase_e            s2_phase_q;
  logic [PROD_W-1:0] s2_prod_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_phase_q <= s1_phase_q;
      s2_prod_q  <= {{CMP_W{1'b0}}, target_q} * {{CMP_W{1'b0}}, s1_mov_q};
    end
  end

  // ---------------- divide stages ----------------
  // Product < target * ramp_ms, so the quotient fits CMP_W bits and the upper
  // half already lies below the divisor. Only the ramping phase uses it.
  phase_e            dv_phase_q [DivStages];
  logic [PROD_W-1:0] dv_word_q  [DivStages];
  logic [PROD_W-1:0] dv_in      [DivStages];
  logic [PROD_W-1:0] dv_out     [DivStages];
  phase_e            dv_phase_in[DivStages];

  for (genvar j = 0; j < DivStages; j++) begin : g_div
    if (j == 0) begin : g_head
      assign dv_in[j]       = s2_prod_q;
      assign dv_phase_in[j] = s2_phase_q;
    end else begin : g_body
      assign dv_in[j]       = dv_word_q[j-1];
      assign dv_phase_in[j] = dv_phase_q[j-1];
    end

    mssr_div_step #(
      .Bits(DivBits)
    ) u_step (
      .word_i   (dv_in[j]),
      .divisor_i(ramp_q),
      .word_o   (dv_out[j])
    );

    always_ff @(posedge clk_i) begin
      if (adv[DivFirst+j]) begin
        dv_word_q[j]  <= dv_out[j];
        dv_phase_q[j] <= dv_phase_in[j];
      end
    end
  end

  // ---------------- output stage: clamp and coast ----------------
  phase_e           fin_phase;
  logic [CMP_W-1:0] drive, clamped;
  logic [CMP_W-1:0] c1_q, c2_q;
  phase_e           ph_q;

  assign fin_phase = dv_phase_q[DivStages-1];

  always_comb begin
    unique case (fin_phase)
      PH_RAMP:   drive = dv_word_q[DivStages-1][CMP_W-1:0];
      PH_CRUISE: drive = target_q;
      default:   drive = '0;  // waiting or timed out
    endcase
    clamped = (drive > period_q) ? period_q : drive;
  end

  always_ff @(posedge clk_i) begin
    if (adv[Last]) begin
      ph_q <= fin_phase;
      if (clamped == '0) begin
        c1_q <= period_q;
        c2_q <= period_q;
      end else begin
        c1_q <= '0;
        c2_q <= clamped;
      end
    end
  end

  assign out_o.valid       = v_q[Last];
  assign out_o.compare_one = c1_q;
  assign out_o.compare_two = c2_q;
  assign out_o.phase       = ph_q;

  // ---------------- assertions ----------------
  `MSSR_ASSERT_IMPL(a_stall_full, clk_i, rst_ni, !in_i.ready,
                    $countones(v_q) == NumStages, "input stalled with a free stage")
  `MSSR_ASSERT_NEXT(a_accept_lands, clk_i, rst_ni, in_i.valid && in_i.ready,
                    v_q[0], "accepted item not captured")
  `MSSR_ASSERT_IMPL(a_coast_phase, clk_i, rst_ni,
                    out_o.valid && (ph_q == PH_WAIT || ph_q == PH_TIMEOUT),
                    c1_q == c2_q && c1_q == period_q, "no coast outside drive phases")
  `MSSR_ASSERT_IMPL(a_drive_form, clk_i, rst_ni, out_o.valid && c1_q != c2_q,
                    c1_q == '0 && c2_q <= period_q, "drive result malformed")

endmodule
